### rtl/sjte_pkg.sv
package sjte_pkg;

    localparam logic [2:0] MODE_CODE  = 3'd0;
    localparam logic [2:0] MODE_STR   = 3'd1;
    localparam logic [2:0] MODE_CHR   = 3'd2;
    localparam logic [2:0] MODE_LINE  = 3'd3;
    localparam logic [2:0] MODE_BLOCK = 3'd4;

    localparam logic [2:0] PEND_NONE  = 3'd0;
    localparam logic [2:0] PEND_LEAD  = 3'd1;
    localparam logic [2:0] PEND_ESC   = 3'd2;
    localparam logic [2:0] PEND_SLASH = 3'd3;
    localparam logic [2:0] PEND_STAR  = 3'd4;
    localparam logic [2:0] PEND_INS   = 3'd5;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_DEL    = 8'h7F;

    localparam logic [7:0] LEAD1_LO  = 8'h81;
    localparam logic [7:0] LEAD1_HI  = 8'h9F;
    localparam logic [7:0] LEAD2_LO  = 8'hE0;
    localparam logic [7:0] LEAD2_HI  = 8'hFC;
    localparam logic [7:0] TRAIL_LO  = 8'h40;
    localparam logic [7:0] TRAIL_HI  = 8'hFC;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       bad_pair;
        logic       out_last;
    } t_result;

    typedef struct packed {
        logic    two;
        t_result res0;
        t_result res1;
    } t_step;

    typedef struct packed {
        logic [2:0] mode;
        logic [2:0] pend;
    } t_scan;

    function automatic logic is_lead(input logic [7:0] b);
        return (b >= LEAD1_LO && b <= LEAD1_HI) || (b >= LEAD2_LO && b <= LEAD2_HI);
    endfunction

    function automatic logic is_trail(input logic [7:0] b);
        return b >= TRAIL_LO && b <= TRAIL_HI && b != CH_DEL;
    endfunction

    // Plain scan of a byte that no pending state has claimed.
    function automatic t_scan scan_byte(input logic [2:0] mode, input logic [7:0] b);
        t_scan s;
        s.mode = mode;
        s.pend = PEND_NONE;
        if (b == CH_DQUOTE) begin
            if (mode == MODE_CODE) s.mode = MODE_STR;
            else if (mode == MODE_STR) s.mode = MODE_CODE;
        end else if (b == CH_SQUOTE) begin
            if (mode == MODE_CODE) s.mode = MODE_CHR;
            else if (mode == MODE_CHR) s.mode = MODE_CODE;
        end else if (is_lead(b)) begin
            s.pend = PEND_LEAD;
        end else if (b == CH_BSLASH) begin
            s.pend = PEND_ESC;
        end else if (mode == MODE_BLOCK && b == CH_STAR) begin
            s.pend = PEND_STAR;
        end else if (mode == MODE_CODE && b == CH_SLASH) begin
            s.pend = PEND_SLASH;
        end
        return s;
    endfunction

endpackage

### rtl/sjte_in_if.sv
interface sjte_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

### rtl/sjte_out_if.sv
interface sjte_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       bad_pair;
    logic       out_last;

    modport source (output valid, output out_byte, output bad_pair, output out_last,
                    input ready);
    modport sink   (input valid, input out_byte, input bad_pair, input out_last,
                    output ready);
endinterface

### rtl/sjte_lexer.sv
module sjte_lexer
    import sjte_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_step      o_step
);

    logic [2:0] r_mode;
    logic [2:0] r_pend;
    logic [2:0] n_mode;
    logic [2:0] n_pend;
    logic [7:0] b;
    logic       bad;
    logic       ins_v;
    logic [7:0] ins_b;
    t_scan      sc;

    always_comb begin
        b      = (i_byte == CH_NUL) ? CH_SPACE : i_byte;
        sc     = scan_byte(r_mode, b);
        n_mode = r_mode;
        n_pend = PEND_NONE;
        bad    = 1'b0;
        ins_v  = 1'b0;
        ins_b  = CH_BSLASH;
        case (r_pend)
            PEND_INS: begin
                ins_v = 1'b1;
                if (b == CH_LF && (r_mode == MODE_LINE || r_mode == MODE_BLOCK))
                    ins_b = CH_UNDER;
                n_mode = sc.mode;
                n_pend = sc.pend;
            end
            PEND_LEAD: begin
                bad = !is_trail(b);
                if (b == CH_BSLASH) n_pend = PEND_INS;
            end
            PEND_ESC: begin
                // An escape swallows the byte unless it opens a double-byte character.
                if (is_lead(b)) begin
                    n_mode = sc.mode;
                    n_pend = sc.pend;
                end
            end
            PEND_SLASH: begin
                if (b == CH_STAR) n_mode = MODE_BLOCK;
                else if (b == CH_SLASH) n_mode = MODE_LINE;
                else begin
                    n_mode = sc.mode;
                    n_pend = sc.pend;
                end
            end
            PEND_STAR: begin
                if (b == CH_SLASH) n_mode = MODE_CODE;
                else begin
                    n_mode = sc.mode;
                    n_pend = sc.pend;
                end
            end
            default: begin
                n_mode = sc.mode;
                n_pend = sc.pend;
            end
        endcase

        if (b == CH_LF && n_mode == MODE_LINE) n_mode = MODE_CODE;
        if (i_last && n_pend == PEND_LEAD) bad = 1'b1;

        o_step.two  = 1'b0;
        o_step.res1 = '{out_byte: CH_BSLASH, bad_pair: 1'b0, out_last: i_last};
        if (ins_v) begin
            o_step.two  = 1'b1;
            o_step.res0 = '{out_byte: ins_b, bad_pair: 1'b0, out_last: 1'b0};
            o_step.res1 = '{out_byte: b, bad_pair: bad, out_last: i_last};
        end else if (i_last && n_pend == PEND_INS) begin
            o_step.two  = 1'b1;
            o_step.res0 = '{out_byte: b, bad_pair: bad, out_last: 1'b0};
        end else begin
            o_step.res0 = '{out_byte: b, bad_pair: bad, out_last: i_last};
        end

        // The final byte of a stream returns the scanner to its reset state.
        if (i_last) begin
            n_mode = MODE_CODE;
            n_pend = PEND_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_CODE;
            r_pend <= PEND_NONE;
        end else if (i_fire) begin
            r_mode <= n_mode;
            r_pend <= n_pend;
        end
    end

endmodule

### rtl/sjte_out_buf.sv
module sjte_out_buf
    import sjte_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  t_step             i_step,
    output logic              o_can_take,
    sjte_out_if.source        o_out
);

    logic [1:0] r_cnt;
    t_result    r_res0;
    t_result    r_res1;
    logic       pop;

    assign pop        = o_out.valid && o_out.ready;
    assign o_can_take = (r_cnt == 2'd0) || (r_cnt == 2'd1 && o_out.ready);

    assign o_out.valid    = r_cnt != 2'd0;
    assign o_out.out_byte = r_res0.out_byte;
    assign o_out.bad_pair = r_res0.bad_pair;
    assign o_out.out_last = r_res0.out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_fire) begin
            r_cnt <= i_step.two ? 2'd2 : 2'd1;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_res0 <= i_step.res0;
            r_res1 <= i_step.res1;
        end else if (pop) begin
            r_res0 <= r_res1;
        end
    end

endmodule

### rtl/sjis_trail_backslash_escaper.sv
// Shift-JIS trail backslash escaper for C source byte streams.
// Input channel i_in carries one source byte per transfer with in_last on the
// final byte of a stream. Output channel o_out carries one result byte per
// transfer: the input byte (a zero byte turned into a space), with an extra
// backslash or underscore placed after a trail byte of 0x5C. bad_pair flags
// a lead byte followed by an invalid trail or by the end of the stream;
// out_last marks the final result. A byte passes the input register and
// the result register before its first result shows on o_out. Throughput
// is one byte per cycle while o_out is ready; an insertion holds the input
// side while the single output port drains the two-entry result register.
// The input register and the result register decouple the two sides: a new
// byte is taken while a finished result waits, and a stall on o_out backs
// up into i_in.ready once both registers are full.
// Synchronous reset clears the lexical mode to plain code, drops any pending
// lookahead and empties both registers. After the final byte of a stream the
// scanner is back in its reset state for the next stream.
module sjis_trail_backslash_escaper
    import sjte_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    sjte_in_if.sink    i_in,
    sjte_out_if.source o_out
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       fire;
    logic       can_take;
    t_step      step;

    assign fire       = r_in_valid && can_take;
    assign i_in.ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.in_byte;
            r_in_last <= i_in.in_last;
        end
    end

    sjte_lexer u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_step  (step)
    );

    sjte_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_step     (step),
        .o_can_take (can_take),
        .o_out      (o_out)
    );

endmodule

### dv/sjis_trail_backslash_escaper_tb.sv
module sjis_trail_backslash_escaper_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sjte_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_BYTES = 430;

    // Tracks the lexical mode and pending byte of the stream and holds the
    // output bytes that each accepted source byte must produce.
    class escape_scoreboard;
        logic [2:0]  mode_q;
        logic [2:0]  pend_q;
        t_result     expected_q[$];
        int unsigned mismatches;
        int unsigned checked;
        int unsigned inserts;
        int unsigned underscores;
        int unsigned flagged;

        function new();
            mode_q = MODE_CODE;
            pend_q = PEND_NONE;
        endfunction

        function logic lead_byte(logic [7:0] b);
            return (b >= LEAD1_LO && b <= LEAD1_HI) || (b >= LEAD2_LO && b <= LEAD2_HI);
        endfunction

        function logic good_trail(logic [7:0] b);
            return b >= TRAIL_LO && b <= TRAIL_HI && b != CH_DEL;
        endfunction

        // Lexing of a byte that is neither a trail nor swallowed by an escape.
        function void scan_plain(logic [7:0] b);
            if (b == CH_DQUOTE) begin
                if (mode_q == MODE_CODE) mode_q = MODE_STR;
                else if (mode_q == MODE_STR) mode_q = MODE_CODE;
            end else if (b == CH_SQUOTE) begin
                if (mode_q == MODE_CODE) mode_q = MODE_CHR;
                else if (mode_q == MODE_CHR) mode_q = MODE_CODE;
            end else if (lead_byte(b)) begin
                pend_q = PEND_LEAD;
            end else if (b == CH_BSLASH) begin
                pend_q = PEND_ESC;
            end else if (mode_q == MODE_BLOCK && b == CH_STAR) begin
                pend_q = PEND_STAR;
            end else if (mode_q == MODE_CODE && b == CH_SLASH) begin
                pend_q = PEND_SLASH;
            end
        endfunction

        function void note_input(logic [7:0] raw, logic last);
            logic [7:0] b;
            logic [2:0] prior;
            t_result    r;
            t_result    ins;
            b = (raw == CH_NUL) ? CH_SPACE : raw;
            prior = pend_q;
            pend_q = PEND_NONE;
            r.out_byte = b;
            r.bad_pair = 1'b0;
            r.out_last = 1'b0;
            ins.bad_pair = 1'b0;
            ins.out_last = 1'b0;
            case (prior)
                PEND_INS: begin
                    ins.out_byte = CH_BSLASH;
                    if (b == CH_LF && (mode_q == MODE_LINE || mode_q == MODE_BLOCK)) begin
                        ins.out_byte = CH_UNDER;
                        underscores++;
                    end
                    expected_q.push_back(ins);
                    inserts++;
                    scan_plain(b);
                end
                PEND_LEAD: begin
                    r.bad_pair = !good_trail(b);
                    if (b == CH_BSLASH) pend_q = PEND_INS;
                end
                PEND_ESC: begin
                    if (lead_byte(b)) scan_plain(b);
                end
                PEND_SLASH: begin
                    if (b == CH_STAR) mode_q = MODE_BLOCK;
                    else if (b == CH_SLASH) mode_q = MODE_LINE;
                    else scan_plain(b);
                end
                PEND_STAR: begin
                    if (b == CH_SLASH) mode_q = MODE_CODE;
                    else scan_plain(b);
                end
                default: scan_plain(b);
            endcase
            if (b == CH_LF && mode_q == MODE_LINE) mode_q = MODE_CODE;
            // A lead byte at the end of the stream never gets its trail.
            if (last && pend_q == PEND_LEAD) r.bad_pair = 1'b1;
            if (r.bad_pair) flagged++;
            if (last && pend_q == PEND_INS) begin
                expected_q.push_back(r);
                ins.out_byte = CH_BSLASH;
                ins.out_last = 1'b1;
                expected_q.push_back(ins);
                inserts++;
            end else begin
                r.out_last = last;
                expected_q.push_back(r);
            end
            if (last) begin
                mode_q = MODE_CODE;
                pend_q = PEND_NONE;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                mismatches++;
                $display("%0t: result with nothing expected: byte %02h bad %0b last %0b",
                         $time, got.out_byte, got.bad_pair, got.out_last);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.out_byte !== want.out_byte) begin
                mismatches++;
                $display("%0t: out_byte expected %02h actual %02h",
                         $time, want.out_byte, got.out_byte);
            end
            if (got.bad_pair !== want.bad_pair) begin
                mismatches++;
                $display("%0t: bad_pair expected %0b actual %0b",
                         $time, want.bad_pair, got.bad_pair);
            end
            if (got.out_last !== want.out_last) begin
                mismatches++;
                $display("%0t: out_last expected %0b actual %0b",
                         $time, want.out_last, got.out_last);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    sjte_in_if  in_if();
    sjte_out_if out_if();

    sjis_trail_backslash_escaper u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    escape_scoreboard sb = new();

    logic [7:0] stream_q[$];
    int         send_idle_pct;
    int         recv_idle_pct;
    int         bytes_sent;
    int         streams_sent;
    int         stall_cycles;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk) begin
        t_result got;
        if (rst_n) begin
            if (out_if.valid && out_if.ready) begin
                got.out_byte = out_if.out_byte;
                got.bad_pair = out_if.bad_pair;
                got.out_last = out_if.out_last;
                sb.check_result(got);
            end
            if ((out_if.valid && out_if.ready) || (in_if.valid && in_if.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                         $time, stall_cycles, sb.pending());
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    function automatic logic [7:0] rand_lead();
        if ($urandom_range(0, 1) == 1) return 8'($urandom_range(LEAD1_LO, LEAD1_HI));
        return 8'($urandom_range(LEAD2_LO, LEAD2_HI));
    endfunction

    // Mostly valid trails, with a heavy share of 0x5C and some arbitrary bytes.
    function automatic logic [7:0] rand_trail();
        int unsigned pick;
        logic [7:0]  t;
        pick = $urandom_range(0, 99);
        if (pick < 30) return CH_BSLASH;
        if (pick < 88) begin
            t = 8'($urandom_range(TRAIL_LO, TRAIL_HI));
            return (t == CH_DEL) ? TRAIL_LO : t;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void add_pair();
        logic [7:0] t;
        t = rand_trail();
        stream_q.push_back(rand_lead());
        stream_q.push_back(t);
        if (t == CH_BSLASH && $urandom_range(0, 2) == 0) stream_q.push_back(CH_LF);
    endfunction

    function automatic void add_body(int n, logic in_block);
        int unsigned pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                add_pair();
            end else if (pick == 8) begin
                if (in_block) begin
                    stream_q.push_back(CH_STAR);
                end else begin
                    stream_q.push_back(CH_BSLASH);
                    stream_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
                end
            end else begin
                stream_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
            end
        end
    endfunction

    function automatic void add_token();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            add_pair();
        end else if (pick < 40) begin
            stream_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
        end else if (pick < 48) begin
            stream_q.push_back(CH_DQUOTE);
            add_body($urandom_range(0, 6), 1'b0);
            stream_q.push_back(CH_DQUOTE);
        end else if (pick < 53) begin
            stream_q.push_back(CH_SQUOTE);
            add_body($urandom_range(0, 2), 1'b0);
            stream_q.push_back(CH_SQUOTE);
        end else if (pick < 61) begin
            stream_q.push_back(CH_SLASH);
            stream_q.push_back(CH_SLASH);
            add_body($urandom_range(0, 6), 1'b0);
            stream_q.push_back(CH_LF);
        end else if (pick < 69) begin
            stream_q.push_back(CH_SLASH);
            stream_q.push_back(CH_STAR);
            add_body($urandom_range(0, 8), 1'b1);
            stream_q.push_back(CH_STAR);
            stream_q.push_back(CH_SLASH);
        end else if (pick < 75) begin
            stream_q.push_back(CH_LF);
        end else if (pick < 80) begin
            stream_q.push_back(CH_BSLASH);
            stream_q.push_back(8'($urandom_range(0, 255)));
        end else if (pick < 85) begin
            stream_q.push_back(CH_NUL);
        end else begin
            stream_q.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid   <= 1'b1;
        in_if.in_byte <= b;
        in_if.in_last <= last;
        do @(posedge clk); while (!in_if.ready);
        sb.note_input(b, last);
        bytes_sent++;
    endtask

    task automatic send_stream();
        int n;
        n = stream_q.size();
        for (int i = 0; i < n; i++) send_byte(stream_q[i], i == n - 1);
        stream_q.delete();
        streams_sent++;
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic run_random(input int target);
        int stop_at;
        int tokens;
        stop_at = bytes_sent + target;
        while (bytes_sent < stop_at) begin
            tokens = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
            repeat (tokens) add_token();
            send_stream();
            if ($urandom_range(0, 24) == 0) wait_drained();
        end
    endtask

    initial begin
        in_if.valid   = 1'b0;
        in_if.in_byte = CH_NUL;
        in_if.in_last = 1'b0;
        out_if.ready  = 1'b0;
        rst_n         = 1'b0;
        send_idle_pct = 11;
        recv_idle_pct = 77;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Zero byte, top byte value, a 0x5C trail before a newline inside a
        // block comment, an escaped quote in a string, a bad trail, a 0x5C
        // trail in a char literal, a line comment and a lead byte at the end.
        stream_q = '{CH_NUL, 8'hFF, CH_SLASH, CH_STAR, 8'h81, CH_BSLASH, CH_LF,
                     CH_STAR, CH_SLASH, CH_DQUOTE, CH_BSLASH, CH_DQUOTE, 8'hE0,
                     CH_DEL, CH_DQUOTE, CH_SQUOTE, 8'hFC, CH_BSLASH, 8'h61,
                     CH_SQUOTE, CH_SLASH, CH_SLASH, 8'h9F, TRAIL_LO, CH_LF, 8'h9F};
        send_stream();
        // A 0x5C trail on the final byte, then a stray escape and a stray
        // slash left pending at the end of their streams.
        stream_q = '{8'h81, CH_BSLASH};
        send_stream();
        stream_q = '{CH_BSLASH};
        send_stream();
        stream_q = '{CH_SLASH};
        send_stream();

        run_random(PHASE_BYTES);
        wait_drained();
        send_idle_pct = 77;
        recv_idle_pct = 11;
        run_random(PHASE_BYTES);
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(PHASE_BYTES);

        wait_drained();
        repeat (8) @(posedge clk);
        $display("Sent %0d bytes in %0d streams under three stall profiles; %0d results checked.",
                 bytes_sent, streams_sent, sb.checked);
        $display("Escapes inserted: %0d (%0d as underscore); flagged pairs: %0d; mismatches: %0d.",
                 sb.inserts, sb.underscores, sb.flagged, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
